>>> src/bqs_pkg.sv
// Shared widths, codes and pipeline types of the biquadratic root solver.
package bqs_pkg;

	localparam int COEF_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int GUARD_BITS = 15;

	localparam int MAG_W  = COEF_WIDTH;
	localparam int PROD_W = 2 * COEF_WIDTH;
	localparam int EXT_W  = PROD_W + 3;
	localparam int DMAG_W = 2 * COEF_WIDTH + 1;
	localparam int DSQ_W  = 2 * ((DMAG_W + 2 * GUARD_BITS + 1) / 2);
	localparam int DQ_W   = DSQ_W / 2;
	localparam int MB_W   = MAG_W + GUARD_BITS;
	localparam int M_W    = ((MB_W > DQ_W) ? MB_W : DQ_W) + 1;
	localparam int N1_W   = M_W + 2 * FRAC_BITS;
	localparam int N2_W   = MAG_W + GUARD_BITS + 1 + 2 * FRAC_BITS;
	localparam int NUM_W  = (N1_W > N2_W) ? N1_W : N2_W;
	localparam int DA_W   = MAG_W + GUARD_BITS + 1;
	localparam int DEN_W  = (DA_W > M_W) ? DA_W : M_W;
	localparam int T_W    = 2 * (COEF_WIDTH - 1);
	localparam int R_W    = COEF_WIDTH - 1;
	localparam int CMP_W  = ((NUM_W > T_W) ? NUM_W : T_W) + 1;

	typedef enum logic [1:0] {DS_NEG, DS_ZERO, DS_POS} dsgn_t;
	typedef enum logic [1:0] {TS_NONE, TS_ZERO, TS_POS} tsgn_t;
	typedef enum logic [1:0] {ST_OK = 2'd0, ST_NONE = 2'd1, ST_AZERO = 2'd2} status_t;

	typedef struct packed {
		logic             a_zero;
		logic             neg_a;
		logic             neg_b;
		logic             neg_c;
		logic [MAG_W-1:0] mag_a;
		logic [MAG_W-1:0] mag_b;
		logic [MAG_W-1:0] mag_c;
		dsgn_t            dsign;
	} coef_meta_t;

	typedef struct packed {
		logic        a_zero;
		tsgn_t [1:0] ts;
	} root_meta_t;

endpackage

>>> src/biquadratic_root_solver_top.sv
// Top level of the biquadratic root solver: pipeline and result serializer.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  coef     | coef_valid / coef_stall | coef_a, coef_b, coef_c
//  root     | root_valid / root_stall | root_value, root_index, root_count, status, last
//
// Items pass through the front stages, the bit-per-stage square root of the discriminant,
// the long division, the bit-per-stage square roots of t and the output register.
// A new item enters every cycle unless the last stage holds an item that the busy output
// register cannot take; an item with k roots (at most 4) stays there until all are sent.
// Reset clears the valid bits of every stage and the output register.
// A stall on the result channel freezes the whole pipeline once its last stage holds an item; nothing is dropped.
module biquadratic_root_solver_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             coef_valid,
	output logic                             coef_stall,
	input  logic signed [bqs_pkg::MAG_W-1:0] coef_a,
	input  logic signed [bqs_pkg::MAG_W-1:0] coef_b,
	input  logic signed [bqs_pkg::MAG_W-1:0] coef_c,
	output logic                             root_valid,
	input  logic                             root_stall,
	output logic signed [bqs_pkg::MAG_W-1:0] root_value,
	output logic [1:0]                       root_index,
	output logic [2:0]                       root_count,
	output logic [1:0]                       status,
	output logic                             last
);
	import bqs_pkg::*;

	logic              adv;
	logic              fr_vld, ds_vld, dv_vld, tail_vld;
	coef_meta_t        fr_meta, ds_meta;
	logic [DMAG_W-1:0] fr_dmag;
	logic [DQ_W-1:0]   ds_q;
	root_meta_t        dv_meta, tail_meta;
	logic [NUM_W-1:0]  dv_quo [2];
	logic [R_W-1:0]    tail_root [2];

	logic [MAG_W-1:0]  pos_v [2];
	logic [MAG_W-1:0]  neg_v [2];
	logic [MAG_W-1:0]  vals_d [4];
	logic [2:0]        n_d;
	status_t           status_d;

	logic              busy_q;
	logic [1:0]        idx_q;
	logic [MAG_W-1:0]  val_q [4];
	logic [2:0]        cnt_q;
	status_t           status_q;
	logic              last_w, xfer, can_take, load;

	bqs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (coef_valid),
		.coef_a   (coef_a),
		.coef_b   (coef_b),
		.coef_c   (coef_c),
		.out_vld  (fr_vld),
		.out_meta (fr_meta),
		.out_dmag (fr_dmag)
	);

	bqs_dsqrt u_dsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (fr_vld),
		.in_meta  (fr_meta),
		.in_dmag  (fr_dmag),
		.out_vld  (ds_vld),
		.out_meta (ds_meta),
		.out_q    (ds_q)
	);

	bqs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (ds_vld),
		.in_meta  (ds_meta),
		.in_q     (ds_q),
		.out_vld  (dv_vld),
		.out_meta (dv_meta),
		.out_quo  (dv_quo)
	);

	bqs_rsqrt u_rsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (dv_vld),
		.in_meta  (dv_meta),
		.in_quo   (dv_quo),
		.out_vld  (tail_vld),
		.out_meta (tail_meta),
		.out_root (tail_root)
	);

	// Lay out the roots in order: a zero t gives one root, a positive t gives +R then -R.
	always_comb begin
		n_d = '0;
		for (int k = 0; k < 4; k++)
			vals_d[k] = '0;
		for (int l = 0; l < 2; l++) begin
			pos_v[l] = MAG_W'(tail_root[l]);
			neg_v[l] = ~pos_v[l] + 1'b1;
			case (tail_meta.ts[l])
				TS_ZERO: begin
					vals_d[n_d[1:0]] = '0;
					n_d = n_d + 3'd1;
				end
				TS_POS: begin
					vals_d[n_d[1:0]]       = pos_v[l];
					vals_d[2'(n_d + 3'd1)] = neg_v[l];
					n_d = n_d + 3'd2;
				end
				default: ;
			endcase
		end
		if (tail_meta.a_zero)
			status_d = ST_AZERO;
		else if (n_d == '0)
			status_d = ST_NONE;
		else
			status_d = ST_OK;
		if (status_d != ST_OK) begin
			n_d = '0;
			for (int k = 0; k < 4; k++)
				vals_d[k] = '0;
		end
	end

	assign last_w     = (cnt_q == '0) || (idx_q == 2'(cnt_q - 3'd1));
	assign xfer       = busy_q && !root_stall;
	assign can_take   = !busy_q || (xfer && last_w);
	assign adv        = can_take || !tail_vld;
	assign load       = tail_vld && can_take;
	assign coef_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (xfer) begin
			if (last_w)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q    <= vals_d;
			cnt_q    <= n_d;
			status_q <= status_d;
		end
	end

	assign root_valid = busy_q;
	assign root_value = $signed(val_q[idx_q]);
	assign root_index = idx_q;
	assign root_count = cnt_q;
	assign status     = status_q;
	assign last       = last_w;

endmodule

>>> src/bqs_front.sv
// Coefficient decode, the two products and the exact discriminant (three stages).
module bqs_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_vld,
	input  logic signed [bqs_pkg::MAG_W-1:0] coef_a,
	input  logic signed [bqs_pkg::MAG_W-1:0] coef_b,
	input  logic signed [bqs_pkg::MAG_W-1:0] coef_c,
	output logic                        out_vld,
	output bqs_pkg::coef_meta_t         out_meta,
	output logic [bqs_pkg::DMAG_W-1:0]  out_dmag
);
	import bqs_pkg::*;

	function automatic logic [MAG_W-1:0] mag_of(logic [MAG_W-1:0] v);
		return v[MAG_W-1] ? (~v + 1'b1) : v;
	endfunction

	logic              vld_s1, vld_s2, vld_s3;
	coef_meta_t        meta_d, meta_s1, meta_s2, meta_s3, meta3_d;
	logic [PROD_W-1:0] p_s2, ac_s2;
	logic [DMAG_W-1:0] dmag_s3, dmag_d;
	logic [EXT_W-1:0]  p_e, q4_e, sum_e, dif_e;
	logic              acneg;

	always_comb begin
		meta_d.neg_a  = coef_a[MAG_W-1];
		meta_d.neg_b  = coef_b[MAG_W-1];
		meta_d.neg_c  = coef_c[MAG_W-1];
		meta_d.mag_a  = mag_of($unsigned(coef_a));
		meta_d.mag_b  = mag_of($unsigned(coef_b));
		meta_d.mag_c  = mag_of($unsigned(coef_c));
		meta_d.a_zero = (coef_a == '0);
		meta_d.dsign  = DS_NEG;
	end

	// One subtraction gives the discriminant's sign unless a, c differ in sign.
	always_comb begin
		acneg   = (meta_s2.mag_c != '0) && (meta_s2.neg_a != meta_s2.neg_c);
		p_e     = EXT_W'(p_s2);
		q4_e    = EXT_W'({ac_s2, 2'b00});
		sum_e   = p_e + q4_e;
		dif_e   = p_e - q4_e;
		meta3_d = meta_s2;
		if (acneg) begin
			dmag_d        = sum_e[DMAG_W-1:0];
			meta3_d.dsign = DS_POS;
		end else begin
			dmag_d = dif_e[DMAG_W-1:0];
			if (dif_e[EXT_W-1])
				meta3_d.dsign = DS_NEG;
			else if (dif_e == '0)
				meta3_d.dsign = DS_ZERO;
			else
				meta3_d.dsign = DS_POS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_d;
			p_s2    <= PROD_W'(meta_s1.mag_b) * PROD_W'(meta_s1.mag_b);
			ac_s2   <= PROD_W'(meta_s1.mag_a) * PROD_W'(meta_s1.mag_c);
			meta_s2 <= meta_s1;
			dmag_s3 <= dmag_d;
			meta_s3 <= meta3_d;
		end
	end

	assign out_vld  = vld_s3;
	assign out_meta = meta_s3;
	assign out_dmag = dmag_s3;

endmodule

>>> src/bqs_dsqrt.sv
// Pipelined square root of the scaled discriminant, one result bit per stage.
module bqs_dsqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_vld,
	input  bqs_pkg::coef_meta_t        in_meta,
	input  logic [bqs_pkg::DMAG_W-1:0] in_dmag,
	output logic                       out_vld,
	output bqs_pkg::coef_meta_t        out_meta,
	output logic [bqs_pkg::DQ_W-1:0]   out_q
);
	import bqs_pkg::*;

	logic [DQ_W-1:0]  vld_s;
	logic [DQ_W+1:0]  rem_s   [DQ_W];
	logic [DQ_W-1:0]  root_s  [DQ_W];
	logic [DSQ_W-1:0] x_s     [DQ_W];
	coef_meta_t       meta_s  [DQ_W];
	logic [DQ_W+1:0]  rem_in  [DQ_W];
	logic [DQ_W-1:0]  root_in [DQ_W];
	logic [DSQ_W-1:0] x_in    [DQ_W];
	coef_meta_t       meta_in [DQ_W];
	logic [DQ_W+1:0]  ra      [DQ_W];
	logic [DQ_W+1:0]  trial   [DQ_W];
	logic             ge      [DQ_W];

	always_comb begin
		rem_in[0]  = '0;
		root_in[0] = '0;
		x_in[0]    = DSQ_W'({in_dmag, {(2 * GUARD_BITS){1'b0}}});
		meta_in[0] = in_meta;
		for (int i = 1; i < DQ_W; i++) begin
			rem_in[i]  = rem_s[i-1];
			root_in[i] = root_s[i-1];
			x_in[i]    = x_s[i-1];
			meta_in[i] = meta_s[i-1];
		end
		for (int i = 0; i < DQ_W; i++) begin
			ra[i]    = {rem_in[i][DQ_W-1:0], x_in[i][DSQ_W-1 -: 2]};
			trial[i] = {root_in[i], 2'b01};
			ge[i]    = (ra[i] >= trial[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[DQ_W-2:0], in_vld};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < DQ_W; i++) begin
				rem_s[i]  <= ge[i] ? (ra[i] - trial[i]) : ra[i];
				root_s[i] <= {root_in[i][DQ_W-2:0], ge[i]};
				x_s[i]    <= {x_in[i][DSQ_W-3:0], 2'b00};
				meta_s[i] <= meta_in[i];
			end
		end
	end

	assign out_vld  = vld_s[DQ_W-1];
	assign out_meta = meta_s[DQ_W-1];
	assign out_q    = root_s[DQ_W-1];

endmodule

>>> src/bqs_div.sv
// Selection of the two quotients for t and their pipelined long division.
module bqs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_vld,
	input  bqs_pkg::coef_meta_t       in_meta,
	input  logic [bqs_pkg::DQ_W-1:0]  in_q,
	output logic                      out_vld,
	output bqs_pkg::root_meta_t       out_meta,
	output logic [bqs_pkg::NUM_W-1:0] out_quo [2]
);
	import bqs_pkg::*;

	logic [M_W-1:0]   m_sum;
	logic [NUM_W-1:0] far_num, near_num, num_d [2];
	logic [DEN_W-1:0] far_den, near_den, den_d [2];
	root_meta_t       rmeta_d;
	logic             acneg, bpos, bnegv;
	logic             z0, p0, z1, p1;

	logic             vld_s1;
	logic [NUM_W-1:0] num_s1 [2];
	logic [DEN_W-1:0] den_s1 [2];
	root_meta_t       rmeta_s1;

	logic [NUM_W-1:0] vld_s;
	logic [DEN_W-1:0] drem_s  [NUM_W][2];
	logic [NUM_W-1:0] nq_s    [NUM_W][2];
	logic [DEN_W-1:0] den_s   [NUM_W][2];
	root_meta_t       meta_s  [NUM_W];
	logic [DEN_W-1:0] drem_in [NUM_W][2];
	logic [NUM_W-1:0] nq_in   [NUM_W][2];
	logic [DEN_W-1:0] den_in  [NUM_W][2];
	root_meta_t       meta_in [NUM_W];
	logic [DEN_W:0]   part    [NUM_W][2];
	logic             ge      [NUM_W][2];

	// The t whose numerator adds magnitudes divides by 2a; the other one is
	// taken as 2c over that sum, which keeps it exact when they nearly cancel.
	always_comb begin
		m_sum    = M_W'({in_meta.mag_b, {GUARD_BITS{1'b0}}}) + M_W'(in_q);
		far_num  = NUM_W'({m_sum, {(2 * FRAC_BITS){1'b0}}});
		far_den  = DEN_W'({in_meta.mag_a, {(GUARD_BITS + 1){1'b0}}});
		near_num = NUM_W'({in_meta.mag_c, {(GUARD_BITS + 1 + 2 * FRAC_BITS){1'b0}}});
		near_den = DEN_W'(m_sum);
		acneg    = (in_meta.mag_c != '0) && (in_meta.neg_a != in_meta.neg_c);
		bpos     = (in_meta.mag_b != '0) && !in_meta.neg_b;
		bnegv    = (in_meta.mag_b != '0) && in_meta.neg_b;
		z0       = bpos && (in_meta.mag_c == '0);
		p0       = !bpos || acneg;
		z1       = bnegv && (in_meta.mag_c == '0);
		p1       = bnegv && !acneg;
		rmeta_d.a_zero = in_meta.a_zero;
		rmeta_d.ts     = {TS_NONE, TS_NONE};
		num_d[0] = bpos ? near_num : far_num;
		den_d[0] = bpos ? near_den : far_den;
		num_d[1] = bnegv ? near_num : far_num;
		den_d[1] = bnegv ? near_den : far_den;
		case (in_meta.dsign)
			DS_ZERO: begin
				num_d[0] = NUM_W'({in_meta.mag_b, {(2 * FRAC_BITS){1'b0}}});
				den_d[0] = DEN_W'({in_meta.mag_a, 1'b0});
				if (in_meta.mag_b == '0)
					rmeta_d.ts[0] = TS_ZERO;
				else if (in_meta.neg_b != in_meta.neg_a)
					rmeta_d.ts[0] = TS_POS;
			end
			DS_POS: begin
				if (z0)
					rmeta_d.ts[0] = TS_ZERO;
				else if (p0 ^ in_meta.neg_a)
					rmeta_d.ts[0] = TS_POS;
				if (z1)
					rmeta_d.ts[1] = TS_ZERO;
				else if (p1 ^ in_meta.neg_a)
					rmeta_d.ts[1] = TS_POS;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			drem_in[0][l] = '0;
			nq_in[0][l]   = num_s1[l];
			den_in[0][l]  = den_s1[l];
		end
		meta_in[0] = rmeta_s1;
		for (int i = 1; i < NUM_W; i++) begin
			for (int l = 0; l < 2; l++) begin
				drem_in[i][l] = drem_s[i-1][l];
				nq_in[i][l]   = nq_s[i-1][l];
				den_in[i][l]  = den_s[i-1][l];
			end
			meta_in[i] = meta_s[i-1];
		end
		for (int i = 0; i < NUM_W; i++) begin
			for (int l = 0; l < 2; l++) begin
				part[i][l] = {drem_in[i][l], nq_in[i][l][NUM_W-1]};
				ge[i][l]   = (part[i][l] >= {1'b0, den_in[i][l]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s  <= '0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s  <= {vld_s[NUM_W-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1   <= num_d;
			den_s1   <= den_d;
			rmeta_s1 <= rmeta_d;
			for (int i = 0; i < NUM_W; i++) begin
				for (int l = 0; l < 2; l++) begin
					drem_s[i][l] <= ge[i][l] ? DEN_W'(part[i][l] - {1'b0, den_in[i][l]})
					                         : part[i][l][DEN_W-1:0];
					nq_s[i][l]   <= {nq_in[i][l][NUM_W-2:0], ge[i][l]};
					den_s[i][l]  <= den_in[i][l];
				end
				meta_s[i] <= meta_in[i];
			end
		end
	end

	assign out_vld    = vld_s[NUM_W-1];
	assign out_meta   = meta_s[NUM_W-1];
	assign out_quo[0] = nq_s[NUM_W-1][0];
	assign out_quo[1] = nq_s[NUM_W-1][1];

endmodule

>>> src/bqs_rsqrt.sv
// Saturation of both t values and their pipelined square roots, two lanes.
module bqs_rsqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_vld,
	input  bqs_pkg::root_meta_t       in_meta,
	input  logic [bqs_pkg::NUM_W-1:0] in_quo [2],
	output logic                      out_vld,
	output bqs_pkg::root_meta_t       out_meta,
	output logic [bqs_pkg::R_W-1:0]   out_root [2]
);
	import bqs_pkg::*;

	logic [CMP_W-1:0] qe [2];
	logic [T_W-1:0]   t_d [2];

	logic             vld_s1;
	logic [T_W-1:0]   t_s1 [2];
	root_meta_t       meta_s1;

	logic [R_W-1:0]   vld_s;
	logic [R_W+1:0]   rem_s   [R_W][2];
	logic [R_W-1:0]   root_s  [R_W][2];
	logic [T_W-1:0]   x_s     [R_W][2];
	root_meta_t       meta_s  [R_W];
	logic [R_W+1:0]   rem_in  [R_W][2];
	logic [R_W-1:0]   root_in [R_W][2];
	logic [T_W-1:0]   x_in    [R_W][2];
	root_meta_t       meta_in [R_W];
	logic [R_W+1:0]   ra      [R_W][2];
	logic [R_W+1:0]   trial   [R_W][2];
	logic             ge      [R_W][2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qe[l]  = CMP_W'(in_quo[l]);
			t_d[l] = (qe[l] > CMP_W'({T_W{1'b1}})) ? {T_W{1'b1}} : qe[l][T_W-1:0];
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rem_in[0][l]  = '0;
			root_in[0][l] = '0;
			x_in[0][l]    = t_s1[l];
		end
		meta_in[0] = meta_s1;
		for (int i = 1; i < R_W; i++) begin
			for (int l = 0; l < 2; l++) begin
				rem_in[i][l]  = rem_s[i-1][l];
				root_in[i][l] = root_s[i-1][l];
				x_in[i][l]    = x_s[i-1][l];
			end
			meta_in[i] = meta_s[i-1];
		end
		for (int i = 0; i < R_W; i++) begin
			for (int l = 0; l < 2; l++) begin
				ra[i][l]    = {rem_in[i][l][R_W-1:0], x_in[i][l][T_W-1 -: 2]};
				trial[i][l] = {root_in[i][l], 2'b01};
				ge[i][l]    = (ra[i][l] >= trial[i][l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s  <= '0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s  <= {vld_s[R_W-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= t_d;
			meta_s1 <= in_meta;
			for (int i = 0; i < R_W; i++) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[i][l]  <= ge[i][l] ? (ra[i][l] - trial[i][l]) : ra[i][l];
					root_s[i][l] <= {root_in[i][l][R_W-2:0], ge[i][l]};
					x_s[i][l]    <= {x_in[i][l][T_W-3:0], 2'b00};
				end
				meta_s[i] <= meta_in[i];
			end
		end
	end

	assign out_vld     = vld_s[R_W-1];
	assign out_meta    = meta_s[R_W-1];
	assign out_root[0] = root_s[R_W-1][0];
	assign out_root[1] = root_s[R_W-1][1];

endmodule

>>> src/bqs_checker.sv
// Port-level checks of the biquadratic root solver and their binding to the top level.
module bqs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             coef_valid,
	input logic                             coef_stall,
	input logic signed [bqs_pkg::MAG_W-1:0] coef_a,
	input logic signed [bqs_pkg::MAG_W-1:0] coef_b,
	input logic signed [bqs_pkg::MAG_W-1:0] coef_c,
	input logic                             root_valid,
	input logic                             root_stall,
	input logic signed [bqs_pkg::MAG_W-1:0] root_value,
	input logic [1:0]                       root_index,
	input logic [2:0]                       root_count,
	input logic [1:0]                       status,
	input logic                             last
);
	import bqs_pkg::*;

	// A stalled coefficient transfer keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && coef_stall |=> coef_valid && $stable(coef_a)
		&& $stable(coef_b) && $stable(coef_c))
		else $error("stalled coefficient transfer changed");

	// A stalled result keeps its whole payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root_stall |=> root_valid && $stable(root_value)
		&& $stable(root_index) && $stable(root_count) && $stable(status) && $stable(last))
		else $error("stalled result changed");

	// Error and empty items are single, zeroed transfers.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && status != ST_OK |-> last && root_index == 2'd0
		&& root_count == 3'd0 && root_value == '0)
		else $error("malformed error or empty item");

	// A root item lies inside its count, and the last one closes it.
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && status == ST_OK |-> root_count != 3'd0
		&& {1'b0, root_index} < root_count
		&& (last == ({1'b0, root_index} == root_count - 3'd1)))
		else $error("root index outside its count");

	// Roots of one input follow back to back with rising index.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && !root_stall && !last |=> root_valid
		&& root_index == 2'($past(root_index) + 2'd1))
		else $error("roots of one input not consecutive");

endmodule

bind biquadratic_root_solver_top bqs_checker u_bqs_checker (.*);
